// ----- design/cbs_pkg.sv -----
// Shared widths, types and helpers for the cubic Bezier split core.
// No dependencies; imported by cbs_lerp and cubic_bezier_split_core.
`default_nettype none

package cbs_pkg;

    // coordinate and parameter formats
    localparam int CW  = 32;          // coordinate width, signed Q16.16
    localparam int TF  = 16;          // fraction bits of t
    localparam int TW  = TF + 2;      // width of t at the port, signed Q1.TF
    localparam int TUW = TF + 1;      // clamped t, unsigned 0..1.0
    localparam int PW  = CW + 1;      // control / level point width
    localparam int DW  = CW + 2;      // difference width
    localparam int PRW = DW + TUW + 1; // difference times t

    localparam logic [TUW-1:0] T_ONE = {1'b1, {TF{1'b0}}};

    // pipeline stage numbering
    localparam int ST_IN  = 1;        // clamp t, form absolute controls
    localparam int ST_L1  = 2;        // first level: diff, product, sum
    localparam int ST_L2  = 5;        // second level
    localparam int ST_L3  = 8;        // third level
    localparam int ST_OUT = 11;       // offsets and saturation
    localparam int NST    = ST_OUT;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [PW-1:0] t_pt;
    typedef logic signed [DW-1:0] t_dif;
    typedef logic        [TUW-1:0] t_tq;

    // load enables of the three stages inside one interpolator
    typedef struct packed {
        logic diff;
        logic prod;
        logic sum;
    } t_lerp_en;

    function automatic t_tq clamp_t(input logic signed [TW-1:0] t);
        t_tq r;
        if (t[TW-1]) begin
            r = '0;
        end else if (t[TW-2:0] > T_ONE) begin
            r = T_ONE;
        end else begin
            r = t[TW-2:0];
        end
        return r;
    endfunction

    function automatic t_coord sat_coord(input t_dif x);
        t_coord r;
        if ((x[DW-1:CW-1] == '0) || (x[DW-1:CW-1] == '1)) begin
            r = x[CW-1:0];
        end else if (x[DW-1]) begin
            r = {1'b1, {(CW-1){1'b0}}};
        end else begin
            r = {1'b0, {(CW-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/cbs_lerp.sv -----
// Three-stage interpolator p + floor((q - p) * t / 2^TF) for one axis.
// Depends on cbs_pkg.
`default_nettype none

module cbs_lerp (
    input  logic              i_clk,
    input  cbs_pkg::t_lerp_en i_en,
    input  cbs_pkg::t_pt      i_p,
    input  cbs_pkg::t_pt      i_q,
    input  cbs_pkg::t_tq      i_t,
    output cbs_pkg::t_pt      o_pt
);
    import cbs_pkg::*;

    t_pt                  r_p1;
    t_dif                 r_d1;
    t_tq                  r_t1;
    t_pt                  r_p2;
    logic signed [PRW-1:0] r_prod;
    t_pt                  r_sum;

    t_dif                  n_d1;
    logic signed [PRW-1:0] n_prod;
    logic signed [PRW-1:0] w_shift;
    t_dif                  n_sum;

    always_comb begin
        n_d1    = t_dif'(i_q) - t_dif'(i_p);
        n_prod  = r_d1 * $signed({1'b0, r_t1});
        // arithmetic shift floors; magnitude never exceeds |q - p|
        w_shift = r_prod >>> TF;
        n_sum   = t_dif'(r_p2) + w_shift[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en.diff) begin
            r_p1 <= i_p;
            r_d1 <= n_d1;
            r_t1 <= i_t;
        end
        if (i_en.prod) begin
            r_p2   <= r_p1;
            r_prod <= n_prod;
        end
        if (i_en.sum) begin
            // result lies between p and q, so it fits the point width
            r_sum <= n_sum[PW-1:0];
        end
    end

    assign o_pt = r_sum;

endmodule

`default_nettype wire

// ----- design/cubic_bezier_split_core.sv -----
// Top level: de Casteljau split of one cubic Bezier segment per word.
// Depends on cbs_pkg and cbs_lerp.
`default_nettype none

// Channel   Dir  Handshake                  Payload
// -------   ---  -------------------------  --------------------------------------
// segment   in   i_valid / o_stall          P0, start handle, end handle, P3, t
// split     out  o_valid / i_stall          left out, mid point, mid in/out, right in
//
// Eleven register stages; one word enters per cycle while o_stall is low, and
// its result leaves from the last stage. Each de Casteljau level takes three
// stages (difference, 34x18 multiply, add), with one multiplier in each
// interpolator. Reset (synchronous, active low) clears only the stage valid bits.
// A stage loads whenever it is empty or the stage after it moves, so bubbles
// close up; o_stall rises only when every stage is full and i_stall is high.

module cubic_bezier_split_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  cbs_pkg::t_coord                  i_start_x,
    input  cbs_pkg::t_coord                  i_start_y,
    input  cbs_pkg::t_coord                  i_start_handle_dx,
    input  cbs_pkg::t_coord                  i_start_handle_dy,
    input  cbs_pkg::t_coord                  i_end_handle_dx,
    input  cbs_pkg::t_coord                  i_end_handle_dy,
    input  cbs_pkg::t_coord                  i_end_x,
    input  cbs_pkg::t_coord                  i_end_y,
    input  logic signed [cbs_pkg::TW-1:0]    i_split_t,
    output logic                             o_valid,
    input  logic                             i_stall,
    output cbs_pkg::t_coord                  o_left_out_dx,
    output cbs_pkg::t_coord                  o_left_out_dy,
    output cbs_pkg::t_coord                  o_mid_x,
    output cbs_pkg::t_coord                  o_mid_y,
    output cbs_pkg::t_coord                  o_mid_in_dx,
    output cbs_pkg::t_coord                  o_mid_in_dy,
    output cbs_pkg::t_coord                  o_mid_out_dx,
    output cbs_pkg::t_coord                  o_mid_out_dy,
    output cbs_pkg::t_coord                  o_right_in_dx,
    output cbs_pkg::t_coord                  o_right_in_dy
);
    import cbs_pkg::*;

    // ---------------------------------------------------------------
    // Flow control: per-stage valid bits and a ready chain from the back
    // ---------------------------------------------------------------
    logic [NST:1] r_vld;
    logic [NST:1] w_adv;
    logic         w_accept;

    always_comb begin
        w_adv[NST] = !r_vld[NST] || !i_stall;
        for (int k = NST - 1; k >= 1; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign o_stall  = !w_adv[ST_IN];
    assign w_accept = i_valid && w_adv[ST_IN];
    assign o_valid  = r_vld[NST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[ST_IN]) begin
                r_vld[ST_IN] <= i_valid;
            end
            for (int k = ST_IN + 1; k <= NST; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Clamped t travels alongside the words up to the last level input
    // ---------------------------------------------------------------
    t_tq r_t [ST_IN:ST_L3-1];

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_IN]) begin
            r_t[ST_IN] <= clamp_t(i_split_t);
        end
        for (int k = ST_IN + 1; k <= ST_L3 - 1; k++) begin
            if (w_adv[k]) begin
                r_t[k] <= r_t[k-1];
            end
        end
    end

    t_lerp_en w_l1en, w_l2en, w_l3en;

    assign w_l1en = '{diff: w_adv[ST_L1], prod: w_adv[ST_L1+1], sum: w_adv[ST_L1+2]};
    assign w_l2en = '{diff: w_adv[ST_L2], prod: w_adv[ST_L2+1], sum: w_adv[ST_L2+2]};
    assign w_l3en = '{diff: w_adv[ST_L3], prod: w_adv[ST_L3+1], sum: w_adv[ST_L3+2]};

    // axis 0 is x, axis 1 is y
    t_coord w_in_p0 [2];
    t_coord w_in_h0 [2];
    t_coord w_in_h3 [2];
    t_coord w_in_p3 [2];

    assign w_in_p0[0] = i_start_x;
    assign w_in_p0[1] = i_start_y;
    assign w_in_h0[0] = i_start_handle_dx;
    assign w_in_h0[1] = i_start_handle_dy;
    assign w_in_h3[0] = i_end_handle_dx;
    assign w_in_h3[1] = i_end_handle_dy;
    assign w_in_p3[0] = i_end_x;
    assign w_in_p3[1] = i_end_y;

    t_coord r_o_lo  [2];
    t_coord r_o_mid [2];
    t_coord r_o_in  [2];
    t_coord r_o_out [2];
    t_coord r_o_ro  [2];

    for (genvar ax = 0; ax < 2; ax++) begin : g_axis
        t_pt  r1_p0, r1_c1, r1_c2, r1_p3;
        t_pt  r_p0c [ST_L1:ST_L2-1];
        t_pt  r_p3c [ST_L1:ST_L2-1];
        t_dif r_lo  [ST_L2:NST-1];
        t_dif r_ro  [ST_L2:NST-1];
        t_pt  r_dc  [ST_L3:NST-1];
        t_pt  r_ec  [ST_L3:NST-1];
        t_pt  w_a, w_b, w_c, w_d, w_e, w_f;

        // absolute controls C1 = P0 + start handle, C2 = P3 + end handle
        always_ff @(posedge i_clk) begin
            if (w_adv[ST_IN]) begin
                r1_p0 <= t_pt'(w_in_p0[ax]);
                r1_p3 <= t_pt'(w_in_p3[ax]);
                r1_c1 <= t_pt'(w_in_p0[ax]) + t_pt'(w_in_h0[ax]);
                r1_c2 <= t_pt'(w_in_p3[ax]) + t_pt'(w_in_h3[ax]);
            end
        end

        // level 1: A, B, C
        cbs_lerp u_la (.i_clk(i_clk), .i_en(w_l1en), .i_p(r1_p0), .i_q(r1_c1),
                       .i_t(r_t[ST_IN]), .o_pt(w_a));
        cbs_lerp u_lb (.i_clk(i_clk), .i_en(w_l1en), .i_p(r1_c1), .i_q(r1_c2),
                       .i_t(r_t[ST_IN]), .o_pt(w_b));
        cbs_lerp u_lc (.i_clk(i_clk), .i_en(w_l1en), .i_p(r1_c2), .i_q(r1_p3),
                       .i_t(r_t[ST_IN]), .o_pt(w_c));

        // end points follow level 1 for the outer handle offsets
        always_ff @(posedge i_clk) begin
            if (w_adv[ST_L1]) begin
                r_p0c[ST_L1] <= r1_p0;
                r_p3c[ST_L1] <= r1_p3;
            end
            for (int k = ST_L1 + 1; k <= ST_L2 - 1; k++) begin
                if (w_adv[k]) begin
                    r_p0c[k] <= r_p0c[k-1];
                    r_p3c[k] <= r_p3c[k-1];
                end
            end
        end

        // level 2: D, E
        cbs_lerp u_ld (.i_clk(i_clk), .i_en(w_l2en), .i_p(w_a), .i_q(w_b),
                       .i_t(r_t[ST_L2-1]), .o_pt(w_d));
        cbs_lerp u_le (.i_clk(i_clk), .i_en(w_l2en), .i_p(w_b), .i_q(w_c),
                       .i_t(r_t[ST_L2-1]), .o_pt(w_e));

        // new outer handles A - P0 and C - P3, carried to the output
        always_ff @(posedge i_clk) begin
            if (w_adv[ST_L2]) begin
                r_lo[ST_L2] <= t_dif'(w_a) - t_dif'(r_p0c[ST_L2-1]);
                r_ro[ST_L2] <= t_dif'(w_c) - t_dif'(r_p3c[ST_L2-1]);
            end
            for (int k = ST_L2 + 1; k <= NST - 1; k++) begin
                if (w_adv[k]) begin
                    r_lo[k] <= r_lo[k-1];
                    r_ro[k] <= r_ro[k-1];
                end
            end
        end

        // level 3: F
        cbs_lerp u_lf (.i_clk(i_clk), .i_en(w_l3en), .i_p(w_d), .i_q(w_e),
                       .i_t(r_t[ST_L3-1]), .o_pt(w_f));

        always_ff @(posedge i_clk) begin
            if (w_adv[ST_L3]) begin
                r_dc[ST_L3] <= w_d;
                r_ec[ST_L3] <= w_e;
            end
            for (int k = ST_L3 + 1; k <= NST - 1; k++) begin
                if (w_adv[k]) begin
                    r_dc[k] <= r_dc[k-1];
                    r_ec[k] <= r_ec[k-1];
                end
            end
        end

        // output stage: mid offsets and saturation of every field
        always_ff @(posedge i_clk) begin
            if (w_adv[NST]) begin
                r_o_lo[ax]  <= sat_coord(r_lo[NST-1]);
                r_o_ro[ax]  <= sat_coord(r_ro[NST-1]);
                r_o_mid[ax] <= sat_coord(t_dif'(w_f));
                r_o_in[ax]  <= sat_coord(t_dif'(r_dc[NST-1]) - t_dif'(w_f));
                r_o_out[ax] <= sat_coord(t_dif'(r_ec[NST-1]) - t_dif'(w_f));
            end
        end
    end

    assign o_left_out_dx = r_o_lo[0];
    assign o_left_out_dy = r_o_lo[1];
    assign o_mid_x       = r_o_mid[0];
    assign o_mid_y       = r_o_mid[1];
    assign o_mid_in_dx   = r_o_in[0];
    assign o_mid_in_dy   = r_o_in[1];
    assign o_mid_out_dx  = r_o_out[0];
    assign o_mid_out_dy  = r_o_out[1];
    assign o_right_in_dx = r_o_ro[0];
    assign o_right_in_dy = r_o_ro[1];

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    // upstream is held off only when the whole pipe is full
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld))
        else $error("input stalled with an empty stage");

    // an accepted word lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_vld[ST_IN])
        else $error("accepted word lost at pipe entry");

    // a full pipe held at the output keeps every word
    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_vld) && i_stall) |=> (&r_vld))
        else $error("word dropped while output stalled");

endmodule

`default_nettype wire
